### src/ppgf_pkg.sv
// ============================================================================
// ppgf_pkg
// Shared constants, types and helpers of the pulse-oximeter report filter.
// ============================================================================
package ppgf_pkg;

    // Samples filtered per report, limited by the four slots a report holds.
    localparam int SAMPLES_PER_REPORT = 4;
    localparam int SLOT_COUNT         = 4;
    localparam int N_SAMPLES = (SAMPLES_PER_REPORT < SLOT_COUNT) ?
                               SAMPLES_PER_REPORT : SLOT_COUNT;
    localparam int SLOT_W    = $clog2(SLOT_COUNT);

    // Filter fraction bits and the widths that follow from them.
    localparam int FRACTION_BITS = 16;
    localparam int X_W    = FRACTION_BITS;         // normalized sample
    localparam int LP_W   = FRACTION_BITS + 1;     // lowpass state
    localparam int INT_W  = FRACTION_BITS + 6;     // blocker integrator
    localparam int COEF_W = 17;                    // Q1.16 coefficient, up to 1.0
    localparam int MB_W   = INT_W;                 // wide multiplier operand
    localparam int PROD_W = COEF_W + MB_W;
    localparam int AC_W   = 18;                    // Q2.16 result
    localparam int SH_UP  = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
    localparam int SH_DN  = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;

    localparam logic [COEF_W-1:0] ONE_Q16 = COEF_W'(65536);

    // Report layout.
    localparam logic [4:0] HDR_POS       = 5'd0;
    localparam logic [4:0] LAST_SMP_POS  = 5'd16;
    localparam logic [4:0] TEMP_INT_POS  = 5'd17;
    localparam logic [4:0] TEMP_FRAC_POS = 5'd18;
    localparam logic [4:0] SEQ_POS       = 5'd19;
    localparam logic [4:0] COUNT_MAX     = 5'd31;
    localparam logic [7:0] REPORT_HEADER = 8'h0E;
    localparam int         RAM_AW        = SLOT_W + 2;

    // Byte offsets inside one sample slot.
    localparam logic [1:0] OFS_RED_HI = 2'd0;
    localparam logic [1:0] OFS_RED_LO = 2'd1;
    localparam logic [1:0] OFS_IR_HI  = 2'd2;
    localparam logic [1:0] OFS_IR_LO  = 2'd3;

    // Configuration registers.
    localparam logic       CFG_LOWPASS_KEEP  = 1'b0;
    localparam logic       CFG_DC_BLOCK_POLE = 1'b1;
    localparam logic [15:0] KEEP_RESET = 16'd45875;
    localparam logic [15:0] POLE_RESET = 16'd62259;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3,
        S_LOAD, S_MUL1, S_MUL2, S_MUL3, S_WB, S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        FOP_NONE, FOP_LOAD, FOP_MUL1, FOP_MUL2, FOP_MUL3, FOP_WB
    } t_fop;

    typedef struct packed {
        t_fop             op;
        logic             chan;   // 0 red, 1 infrared
        logic [X_W-1:0]   x;
        logic [15:0]      keep;
        logic [15:0]      pole;
    } t_fctrl;

    typedef struct packed {
        logic       fire;
        logic [7:0] seq;
        logic [7:0] temp_int;
        logic [3:0] temp_frac;
    } t_report;

    // Inverts a raw sample and scales it to FRACTION_BITS fraction bits.
    function automatic logic [X_W-1:0] normalize(input logic [15:0] raw);
        logic [15:0]        v;
        logic [15+SH_UP:0]  up;
        v  = ~raw;
        up = (16 + SH_UP)'(v) << SH_UP;
        if (FRACTION_BITS >= 16) begin
            return X_W'(up);
        end else begin
            return X_W'(v >> SH_DN);
        end
    endfunction

endpackage

### src/ppgf_capture.sv
// ============================================================================
// ppgf_capture
// Report byte capture: sample bytes to a small RAM, header and temperature
// bytes to registers; flags a valid report on its last, the sequence byte.
// ============================================================================
module ppgf_capture (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [7:0]                    i_byte,
    input  logic                          i_last,
    input  logic [ppgf_pkg::RAM_AW-1:0]   i_rd_addr,
    output logic [7:0]                    o_rd_data,
    output ppgf_pkg::t_report             o_report
);

    logic [7:0] mem [2**ppgf_pkg::RAM_AW];
    logic [4:0] r_count;
    logic [4:0] n_count;
    logic [7:0] r_hdr;
    logic [7:0] r_temp_int;
    logic [3:0] r_temp_frac;
    logic [7:0] r_rd_data;
    logic       wr_en;
    logic [ppgf_pkg::RAM_AW-1:0] wr_addr;

    assign wr_en   = i_take && (r_count != ppgf_pkg::HDR_POS) &&
                     (r_count <= ppgf_pkg::LAST_SMP_POS);
    assign wr_addr = ppgf_pkg::RAM_AW'(r_count - 5'd1);

    always_comb begin
        n_count = r_count;
        if (i_take) begin
            if (i_last) begin
                n_count = '0;
            end else if (r_count != ppgf_pkg::COUNT_MAX) begin
                n_count = r_count + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_byte;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            if (r_count == ppgf_pkg::HDR_POS) begin
                r_hdr <= i_byte;
            end
            if (r_count == ppgf_pkg::TEMP_INT_POS) begin
                r_temp_int <= i_byte;
            end
            if (r_count == ppgf_pkg::TEMP_FRAC_POS) begin
                r_temp_frac <= i_byte[3:0];
            end
        end
    end

    assign o_rd_data = r_rd_data;

    // A report counts only if its last byte is the twentieth and the header fits.
    assign o_report.fire      = i_take && i_last && (r_count == ppgf_pkg::SEQ_POS) &&
                                (r_hdr == ppgf_pkg::REPORT_HEADER);
    assign o_report.seq       = i_byte;
    assign o_report.temp_int  = r_temp_int;
    assign o_report.temp_frac = r_temp_frac;

endmodule

### src/ppgf_filter.sv
// ============================================================================
// ppgf_filter
// Shared lowpass and DC-blocker datapath; per-channel filter state lives in
// a two-entry RAM that is read, updated and written back per sample.
// ============================================================================
module ppgf_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ppgf_pkg::t_fctrl                    i_ctrl,
    output logic signed [ppgf_pkg::AC_W-1:0]    o_red_ac,
    output logic signed [ppgf_pkg::AC_W-1:0]    o_ir_ac
);

    localparam int ST_W = ppgf_pkg::LP_W + ppgf_pkg::INT_W;
    localparam int QW   = ppgf_pkg::INT_W + 1 + ppgf_pkg::SH_DN;
    localparam logic signed [QW-1:0] AC_MAX = QW'((1 <<< (ppgf_pkg::AC_W - 1)) - 1);
    localparam logic signed [QW-1:0] AC_MIN = -QW'(1 <<< (ppgf_pkg::AC_W - 1));
    localparam logic [ppgf_pkg::PROD_W:0] HALF = (ppgf_pkg::PROD_W + 1)'(32768);

    logic [ST_W-1:0]                  mem [2];
    logic [1:0]                       r_vld;
    logic [ST_W-1:0]                  r_rd_data;
    logic                             r_rd_vld;
    logic [ppgf_pkg::LP_W-1:0]        lp_cur;
    logic [ppgf_pkg::INT_W-1:0]       int_cur;
    logic [ppgf_pkg::COEF_W-1:0]      mul_a;
    logic [ppgf_pkg::MB_W-1:0]        mul_b;
    logic [ppgf_pkg::PROD_W-1:0]      r_prod;
    logic [ppgf_pkg::PROD_W-1:0]      r_acc;
    logic [ppgf_pkg::LP_W-1:0]        r_y;
    logic [ppgf_pkg::PROD_W:0]        lp_sum;
    logic [ppgf_pkg::PROD_W:0]        dc_sum;
    logic [ppgf_pkg::INT_W:0]         f_sum;
    logic [ppgf_pkg::INT_W-1:0]       f_sat;
    logic signed [ppgf_pkg::INT_W+1:0] diff;
    logic signed [QW-1:0]             q;
    logic signed [ppgf_pkg::AC_W-1:0] ac;
    logic signed [ppgf_pkg::AC_W-1:0] r_red_ac;
    logic signed [ppgf_pkg::AC_W-1:0] r_ir_ac;

    // An entry never written since reset reads as zero state.
    assign lp_cur  = r_rd_vld ? r_rd_data[ST_W-1:ppgf_pkg::INT_W] : '0;
    assign int_cur = r_rd_vld ? r_rd_data[ppgf_pkg::INT_W-1:0] : '0;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.op)
            ppgf_pkg::FOP_MUL1: begin
                mul_a = ppgf_pkg::COEF_W'(i_ctrl.keep);
                mul_b = ppgf_pkg::MB_W'(lp_cur);
            end
            ppgf_pkg::FOP_MUL2: begin
                mul_a = ppgf_pkg::ONE_Q16 - ppgf_pkg::COEF_W'(i_ctrl.keep);
                mul_b = ppgf_pkg::MB_W'(i_ctrl.x);
            end
            ppgf_pkg::FOP_MUL3: begin
                mul_a = ppgf_pkg::COEF_W'(i_ctrl.pole);
                mul_b = int_cur;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        lp_sum = (ppgf_pkg::PROD_W + 1)'(r_acc) + (ppgf_pkg::PROD_W + 1)'(r_prod) + HALF;
        dc_sum = (ppgf_pkg::PROD_W + 1)'(r_prod) + HALF;
        f_sum  = (ppgf_pkg::INT_W + 1)'(r_y) +
                 (ppgf_pkg::INT_W + 1)'(dc_sum[ppgf_pkg::PROD_W:16]);
        f_sat  = f_sum[ppgf_pkg::INT_W] ? '1 : f_sum[ppgf_pkg::INT_W-1:0];
        diff   = $signed({2'b00, f_sat}) - $signed({2'b00, int_cur});
        // Back to Q2.16, flooring on the way down.
        if (ppgf_pkg::FRACTION_BITS >= 16) begin
            q = QW'(diff) >>> ppgf_pkg::SH_UP;
        end else begin
            q = QW'(diff) <<< ppgf_pkg::SH_DN;
        end
        if (q > AC_MAX) begin
            ac = ppgf_pkg::AC_W'(AC_MAX);
        end else if (q < AC_MIN) begin
            ac = ppgf_pkg::AC_W'(AC_MIN);
        end else begin
            ac = ppgf_pkg::AC_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == ppgf_pkg::FOP_WB) begin
            mem[i_ctrl.chan] <= {r_y, f_sat};
        end
        if (i_ctrl.op == ppgf_pkg::FOP_LOAD) begin
            r_rd_data <= mem[i_ctrl.chan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctrl.op == ppgf_pkg::FOP_WB) begin
                r_vld[i_ctrl.chan] <= 1'b1;
            end
            if (i_ctrl.op == ppgf_pkg::FOP_LOAD) begin
                r_rd_vld <= r_vld[i_ctrl.chan];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_ctrl.op == ppgf_pkg::FOP_MUL2) begin
            r_acc <= r_prod;
        end
        if (i_ctrl.op == ppgf_pkg::FOP_MUL3) begin
            r_y <= lp_sum[ppgf_pkg::LP_W+15:16];
        end
        if (i_ctrl.op == ppgf_pkg::FOP_WB) begin
            if (i_ctrl.chan) begin
                r_ir_ac <= ac;
            end else begin
                r_red_ac <= ac;
            end
        end
    end

    assign o_red_ac = r_red_ac;
    assign o_ir_ac  = r_ir_ac;

endmodule

### src/ppg_report_filter.sv
// ============================================================================
// ppg_report_filter
// Pulse-oximeter report filter: checks reports, tracks sequence numbers and
// runs each red/infrared sample through a lowpass and a DC blocker.
// ============================================================================
//
//  Channel  Direction  Word contents
//  s_*      in         tdata: report byte; tlast: last byte of the report
//  m_*      out        tdata: red_ac, ir_ac, temp, index; tuser: packet lost;
//                      tlast: final sample of the report
//  i_cfg_*  in         plain register write, index 0 keep, 1 pole
//
// A report byte is taken whenever the sequencer is idle. The final byte of
// an accepted report starts the sequencer, which for each sample reads its
// four bytes from the report RAM in states RD0 to RD3, then runs each
// channel through the shared filter multiplier in LOAD, MUL1, MUL2, MUL3
// and WB and loads the output register in EMIT; input stays stalled until
// the last result is in the output register. A stalled output only holds
// the sequencer in its emit state. Reset is synchronous and active low;
// filter state reads as zero until first written, no clearing pass runs.
//
module ppg_report_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Report input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [17:0] red_ac, [35:18] ir_ac,
                                   // [48:36] temp_sixteenths, [80:49] sample_index,
                                   // [87:81] zero
    output logic        m_tuser,   // [0] packet_lost
    output logic        m_tlast,
    // Configuration.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    ppgf_pkg::t_state r_state;
    ppgf_pkg::t_state n_state;

    ppgf_pkg::t_report             rep;
    ppgf_pkg::t_fctrl              fctrl;
    logic                          take;
    logic [ppgf_pkg::RAM_AW-1:0]   rd_addr;
    logic [7:0]                    rd_data;
    logic signed [ppgf_pkg::AC_W-1:0] red_ac;
    logic signed [ppgf_pkg::AC_W-1:0] ir_ac;

    logic [15:0]                   r_keep;
    logic [15:0]                   r_pole;
    logic [ppgf_pkg::SLOT_W-1:0]   r_slot;
    logic                          r_chan;
    logic                          r_seen;
    logic [7:0]                    r_exp_seq;
    logic                          r_lost;
    logic signed [12:0]            r_temp;
    logic [15:0]                   r_red_raw;
    logic [15:0]                   r_ir_raw;
    logic [31:0]                   r_sample_cnt;

    logic                          r_out_valid;
    logic signed [ppgf_pkg::AC_W-1:0] r_out_red;
    logic signed [ppgf_pkg::AC_W-1:0] r_out_ir;
    logic signed [12:0]            r_out_temp;
    logic [31:0]                   r_out_idx;
    logic                          r_out_lost;
    logic                          r_out_last;

    logic                          out_load;
    logic                          last_slot;
    logic [7:0]                    exp_now;
    logic signed [12:0]            temp_now;

    assign s_tready  = (r_state == ppgf_pkg::S_IDLE);
    assign take      = s_tvalid && s_tready;
    assign out_load  = (r_state == ppgf_pkg::S_EMIT) && (!r_out_valid || m_tready);
    assign last_slot = (r_slot == ppgf_pkg::SLOT_W'(ppgf_pkg::N_SAMPLES - 1));

    ppgf_capture u_capture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_byte    (s_tdata),
        .i_last    (s_tlast),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_report  (rep)
    );

    ppgf_filter u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (fctrl),
        .o_red_ac (red_ac),
        .o_ir_ac  (ir_ac)
    );

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppgf_pkg::S_IDLE: begin
                if (rep.fire) begin
                    n_state = ppgf_pkg::S_RD0;
                end
            end
            ppgf_pkg::S_RD0:  n_state = ppgf_pkg::S_RD1;
            ppgf_pkg::S_RD1:  n_state = ppgf_pkg::S_RD2;
            ppgf_pkg::S_RD2:  n_state = ppgf_pkg::S_RD3;
            ppgf_pkg::S_RD3:  n_state = ppgf_pkg::S_LOAD;
            ppgf_pkg::S_LOAD: n_state = ppgf_pkg::S_MUL1;
            ppgf_pkg::S_MUL1: n_state = ppgf_pkg::S_MUL2;
            ppgf_pkg::S_MUL2: n_state = ppgf_pkg::S_MUL3;
            ppgf_pkg::S_MUL3: n_state = ppgf_pkg::S_WB;
            ppgf_pkg::S_WB: begin
                n_state = r_chan ? ppgf_pkg::S_EMIT : ppgf_pkg::S_LOAD;
            end
            ppgf_pkg::S_EMIT: begin
                if (out_load) begin
                    n_state = last_slot ? ppgf_pkg::S_IDLE : ppgf_pkg::S_RD0;
                end
            end
            default: n_state = ppgf_pkg::S_IDLE;
        endcase
    end

    // Sequencer: RAM addresses and filter commands.
    always_comb begin
        rd_addr    = {r_slot, ppgf_pkg::OFS_RED_HI};
        fctrl.op   = ppgf_pkg::FOP_NONE;
        fctrl.chan = r_chan;
        fctrl.x    = r_chan ? ppgf_pkg::normalize(r_ir_raw) :
                              ppgf_pkg::normalize(r_red_raw);
        fctrl.keep = r_keep;
        fctrl.pole = r_pole;
        case (r_state)
            ppgf_pkg::S_RD0:  rd_addr  = {r_slot, ppgf_pkg::OFS_RED_HI};
            ppgf_pkg::S_RD1:  rd_addr  = {r_slot, ppgf_pkg::OFS_RED_LO};
            ppgf_pkg::S_RD2:  rd_addr  = {r_slot, ppgf_pkg::OFS_IR_HI};
            ppgf_pkg::S_RD3:  rd_addr  = {r_slot, ppgf_pkg::OFS_IR_LO};
            ppgf_pkg::S_LOAD: fctrl.op = ppgf_pkg::FOP_LOAD;
            ppgf_pkg::S_MUL1: fctrl.op = ppgf_pkg::FOP_MUL1;
            ppgf_pkg::S_MUL2: fctrl.op = ppgf_pkg::FOP_MUL2;
            ppgf_pkg::S_MUL3: fctrl.op = ppgf_pkg::FOP_MUL3;
            ppgf_pkg::S_WB:   fctrl.op = ppgf_pkg::FOP_WB;
            default:          fctrl.op = ppgf_pkg::FOP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppgf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= ppgf_pkg::KEEP_RESET;
            r_pole <= ppgf_pkg::POLE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ppgf_pkg::CFG_LOWPASS_KEEP) begin
                r_keep <= i_cfg_data;
            end
            if (i_cfg_idx == ppgf_pkg::CFG_DC_BLOCK_POLE) begin
                r_pole <= i_cfg_data;
            end
        end
    end

    // The first accepted report seeds the expected sequence number.
    assign exp_now  = r_seen ? r_exp_seq : rep.seq;
    assign temp_now = $signed({rep.temp_int[7], rep.temp_int, 4'b0000}) -
                      $signed({9'd0, rep.temp_frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_exp_seq    <= '0;
            r_sample_cnt <= '0;
            r_slot       <= '0;
            r_chan       <= 1'b0;
        end else begin
            if (rep.fire) begin
                r_seen    <= 1'b1;
                r_exp_seq <= rep.seq + 8'd1;
                r_slot    <= '0;
            end
            if (r_state == ppgf_pkg::S_RD0) begin
                r_chan <= 1'b0;
            end else if ((r_state == ppgf_pkg::S_WB) && !r_chan) begin
                r_chan <= 1'b1;
            end
            if (out_load) begin
                r_sample_cnt <= r_sample_cnt + 32'd1;
                r_slot       <= r_slot + ppgf_pkg::SLOT_W'(1);
            end
        end
    end

    // Report fields and the raw sample bytes, one byte a cycle from the RAM.
    always_ff @(posedge i_clk) begin
        if (rep.fire) begin
            r_lost <= (exp_now != rep.seq);
            r_temp <= temp_now;
        end
        case (r_state)
            ppgf_pkg::S_RD1: r_red_raw[15:8] <= rd_data;
            ppgf_pkg::S_RD2: r_red_raw[7:0]  <= rd_data;
            ppgf_pkg::S_RD3: r_ir_raw[15:8]  <= rd_data;
            ppgf_pkg::S_LOAD: begin
                if (!r_chan) begin
                    r_ir_raw[7:0] <= rd_data;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: the next report can come in while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_red  <= red_ac;
            r_out_ir   <= ir_ac;
            r_out_temp <= r_temp;
            r_out_idx  <= r_sample_cnt;
            r_out_lost <= r_lost;
            r_out_last <= last_slot;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'd0, r_out_idx, r_out_temp, r_out_ir, r_out_red};
    assign m_tuser  = r_out_lost;
    assign m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // An accepted report always starts the sample sequence.
    a_fire_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rep.fire |=> (r_state == ppgf_pkg::S_RD0))
        else $error("accepted report did not start the sequencer");

    // The last sample of a report returns the sequencer to idle.
    a_last_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && last_slot) |=> (r_state == ppgf_pkg::S_IDLE) && m_tlast)
        else $error("sequencer did not finish after the last sample");

    // The sample index advances once per loaded result and never otherwise.
    a_index_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_sample_cnt == $past(r_sample_cnt) + 32'd1) &&
                     (r_out_idx == $past(r_sample_cnt)))
        else $error("sample index out of step with results");

    // No report byte is taken while the sequencer works on a report.
    a_no_take_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ppgf_pkg::S_IDLE) |-> !take && !rep.fire)
        else $error("report byte taken while busy");
`endif

endmodule

### dv/ppg_report_filter_tb.sv
// ============================================================================
// ppg_report_filter_tb
// Self-checking bench for the pulse-oximeter report filter. Report bytes go
// in on the input stream, and a predictor works out every filtered sample.
// Each output word is checked field by field against the predicted samples,
// in order. A directed table of reports comes first, then random phases
// that use different filter settings and different idle and stall patterns.
// ============================================================================
module ppg_report_filter_tb;

    localparam int     RPT_LEN      = 20;
    localparam int     RPT_BUF_LEN  = 40;
    localparam int     SEQ_NEXT     = -1;       // use the sequence number the filter expects
    localparam int     NOCHK        = 999999;   // field is left to the predictor
    localparam int     DRAIN_CYCLES = 40;
    localparam int     PHASE_BYTES  = 30;
    localparam int     N_PHASES     = 4;
    localparam int     Q_DEPTH      = 16;
    localparam longint ACC_MAX      = (longint'(1) << ppgf_pkg::INT_W) - 1;
    localparam longint AC_MAX       = 131071;
    localparam longint AC_MIN       = -131072;
    localparam logic [7:0] HDR_OK   = ppgf_pkg::REPORT_HEADER;

    typedef enum logic [1:0] {FILL_MIXED, FILL_RAW_MIN, FILL_RAW_MAX} t_fill;
    typedef enum logic [1:0] {ROW_REPORT, ROW_SETUP} t_row_kind;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // One filtered sample as it leaves the block.
    typedef struct packed {
        logic [ppgf_pkg::AC_W-1:0] red_ac;
        logic [ppgf_pkg::AC_W-1:0] ir_ac;
        logic [12:0]               temp;
        logic [31:0]               index;
        logic                      lost;
        logic                      last;
    } t_sample;

    // One row of the directed script: either a report (sent rep times) or a
    // change of the filter settings. Typed expectations override the
    // predictor for the fields they name.
    typedef struct packed {
        t_row_kind   kind;
        int          len;
        logic [7:0]  hdr;
        int          seq;
        t_fill       fill;
        logic [7:0]  t_int;
        logic [7:0]  t_frac;
        int          rep;
        logic        dropped;
        int          exp_lost;
        int          exp_temp;
        int          exp_idx;
        logic [15:0] keep;
        logic [15:0] pole;
    } t_script_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata    = 8'd0;   // [7:0] in_byte
    logic        s_tlast    = 1'b0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [87:0] m_tdata;             // [17:0] red_ac, [35:18] ir_ac,
                                      // [48:36] temp_sixteenths, [80:49] sample_index
    logic        m_tuser;             // [0] packet_lost
    logic        m_tlast;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = ppgf_pkg::CFG_LOWPASS_KEEP;
    logic [15:0] i_cfg_data = 16'd0;

    ppg_report_filter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The whole run should finish long before this; a hang ends here.
    initial begin
        #600000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the report store, sequence tracking,
    // both filter chains and the filter settings.
    // ------------------------------------------------------------------------
    logic [7:0]                 rpt_buf [RPT_LEN];
    logic [4:0]                 rpt_len       = 5'd0;
    logic                       seq_seeded    = 1'b0;
    logic [7:0]                 seq_next      = 8'd0;
    logic [ppgf_pkg::LP_W-1:0]  lp_st  [2]    = '{default: '0};   // index 0 red, 1 infrared
    logic [ppgf_pkg::INT_W-1:0] acc_st [2]    = '{default: '0};
    logic [31:0]                sample_count  = 32'd0;
    logic [15:0]                keep_q16      = ppgf_pkg::KEEP_RESET;
    logic [15:0]                pole_q16      = ppgf_pkg::POLE_RESET;

    // Predicted samples not yet seen, oldest at pend_rd.
    t_sample     pend_q [Q_DEPTH];
    int          pend_wr           = 0;
    int          pend_rd           = 0;
    int          samples_predicted = 0;
    int          error_count       = 0;
    int          tx_gap_pct        = 0;
    int          rx_stall_pct      = 0;

    // One sample through the lowpass and then the DC blocker of one channel.
    // Returns the AC value in Q2.16, saturated.
    function automatic logic [ppgf_pkg::AC_W-1:0] lowpass_dc_block(input int ch,
                                                                   input logic [15:0] raw);
        longint x;
        longint y;
        longint f;
        longint ac;
        x = longint'(16'hFFFF - raw);
        if (ppgf_pkg::FRACTION_BITS >= 16) begin
            x = x <<< ppgf_pkg::SH_UP;
        end else begin
            x = x >>> ppgf_pkg::SH_DN;
        end
        y = (longint'(keep_q16) * longint'(lp_st[ch])
             + (65536 - longint'(keep_q16)) * x + 32768) >>> 16;
        f = y + ((longint'(pole_q16) * longint'(acc_st[ch]) + 32768) >>> 16);
        if (f > ACC_MAX) begin
            f = ACC_MAX;
        end
        ac = f - longint'(acc_st[ch]);
        lp_st[ch]  = ppgf_pkg::LP_W'(y);
        acc_st[ch] = ppgf_pkg::INT_W'(f);
        // Arithmetic shift rounds toward minus infinity, as the output wants.
        if (ppgf_pkg::FRACTION_BITS >= 16) begin
            ac = ac >>> ppgf_pkg::SH_UP;
        end else begin
            ac = ac <<< ppgf_pkg::SH_DN;
        end
        if (ac > AC_MAX) begin
            ac = AC_MAX;
        end
        if (ac < AC_MIN) begin
            ac = AC_MIN;
        end
        return ppgf_pkg::AC_W'(ac);
    endfunction

    // Appends one predicted sample to the buffer of samples still expected.
    function automatic void store_sample(input t_sample s);
        if (pend_wr - pend_rd >= Q_DEPTH) begin
            $error("predicted sample buffer overflow");
            error_count++;
        end
        pend_q[pend_wr % Q_DEPTH] = s;
        pend_wr++;
    endfunction

    // Takes one accepted report byte. At the end of a good report, queues
    // the samples that it causes.
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        int          n;
        int          base;
        int          t;
        logic [7:0]  seq;
        logic        lost;
        t_sample     s;
        if (rpt_len < RPT_LEN) begin
            rpt_buf[rpt_len] = b;
        end
        if (rpt_len < ppgf_pkg::COUNT_MAX) begin
            rpt_len = rpt_len + 5'd1;
        end
        if (!last) begin
            return;
        end
        n = int'(rpt_len);
        rpt_len = 5'd0;
        if (n != RPT_LEN || rpt_buf[ppgf_pkg::HDR_POS] != ppgf_pkg::REPORT_HEADER) begin
            return;
        end
        // The first good report only seeds the expected sequence number.
        seq = rpt_buf[ppgf_pkg::SEQ_POS];
        if (!seq_seeded) begin
            seq_seeded = 1'b1;
            seq_next   = seq;
        end
        lost     = (seq_next != seq);
        seq_next = seq + 8'd1;
        t = $signed(rpt_buf[ppgf_pkg::TEMP_INT_POS]) * 16 -
            int'(rpt_buf[ppgf_pkg::TEMP_FRAC_POS][3:0]);
        for (int k = 0; k < ppgf_pkg::N_SAMPLES; k++) begin
            base     = 1 + 4 * k;
            s.red_ac = lowpass_dc_block(0, {rpt_buf[base + ppgf_pkg::OFS_RED_HI],
                                            rpt_buf[base + ppgf_pkg::OFS_RED_LO]});
            s.ir_ac  = lowpass_dc_block(1, {rpt_buf[base + ppgf_pkg::OFS_IR_HI],
                                            rpt_buf[base + ppgf_pkg::OFS_IR_LO]});
            s.temp   = t[12:0];
            s.index  = sample_count;
            s.lost   = lost;
            s.last   = (k == ppgf_pkg::N_SAMPLES - 1);
            sample_count = sample_count + 32'd1;
            store_sample(s);
            samples_predicted++;
        end
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, and every accepted word is compared with
    // the oldest predicted sample.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_sample seen;
        t_sample want;
        if (i_rst_n && m_tvalid && m_tready) begin
            seen.red_ac = m_tdata[17:0];
            seen.ir_ac  = m_tdata[35:18];
            seen.temp   = m_tdata[48:36];
            seen.index  = m_tdata[80:49];
            seen.lost   = m_tuser;
            seen.last   = m_tlast;
            if (pend_wr == pend_rd) begin
                $error("unexpected result word, sample_index %0d", seen.index);
                error_count++;
            end else begin
                want = pend_q[pend_rd % Q_DEPTH];
                pend_rd++;
                check_field("red_ac", $signed(want.red_ac), $signed(seen.red_ac));
                check_field("ir_ac", $signed(want.ir_ac), $signed(seen.ir_ac));
                check_field("temp_sixteenths", $signed(want.temp), $signed(seen.temp));
                check_field("sample_index", want.index, seen.index);
                check_field("packet_lost", want.lost, seen.lost);
                check_field("last_of_report", want.last, seen.last);
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------
    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            IDLE_SENDER: begin
                tx_gap_pct   = 60;
                rx_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                tx_gap_pct   = 0;
                rx_stall_pct = 60;
            end
            default: begin
                tx_gap_pct   = 22;
                rx_stall_pct = 22;
            end
        endcase
    endtask

    // Offers one byte and returns in the time step of its handshake. Valid
    // stays up, so a following byte can go out on the very next edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        predict_byte(b, last);
    endtask

    // Builds a report and sends its first len bytes, the last one marked.
    // Bytes past the twentieth of a long report are random filler.
    task automatic send_report(input int len, input logic [7:0] hdr, input int seq,
                               input t_fill fill, input logic [7:0] t_int,
                               input logic [7:0] t_frac);
        logic [7:0] body [RPT_BUF_LEN];
        logic [7:0] raw_byte;
        for (int i = 0; i < RPT_BUF_LEN; i++) begin
            body[i] = 8'($urandom);
        end
        body[ppgf_pkg::HDR_POS] = hdr;
        // Eight 16-bit raw values: red and infrared of four sample slots.
        for (int p = 0; p < 8; p++) begin
            case (fill)
                FILL_RAW_MIN: raw_byte = 8'h00;
                FILL_RAW_MAX: raw_byte = 8'hFF;
                default:      raw_byte = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
            endcase
            if (fill != FILL_MIXED || $urandom_range(0, 1) == 0) begin
                body[1 + 2 * p] = raw_byte;
                body[2 + 2 * p] = raw_byte;
            end
        end
        body[ppgf_pkg::TEMP_INT_POS]  = t_int;
        body[ppgf_pkg::TEMP_FRAC_POS] = t_frac;
        body[ppgf_pkg::SEQ_POS]       = (seq == SEQ_NEXT) ? seq_next : 8'(seq);
        for (int i = 0; i < len; i++) begin
            send_byte(body[i], i == len - 1);
        end
    endtask

    // Waits until the block is idle: input quiet, every predicted sample
    // seen, and a DRAIN_CYCLES wait for a dropped report still in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pend_wr != pend_rd) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_filter_cfg(input logic [15:0] keep, input logic [15:0] pole);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ppgf_pkg::CFG_LOWPASS_KEEP;
        i_cfg_data <= keep;
        @(posedge i_clk);
        i_cfg_idx  <= ppgf_pkg::CFG_DC_BLOCK_POLE;
        i_cfg_data <= pole;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        keep_q16 = keep;
        pole_q16 = pole;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    t_script_row script [16];

    initial begin : stimulus
        logic [15:0] phase_keep [N_PHASES];
        logic [15:0] phase_pole [N_PHASES];
        t_idle_mode  phase_idle [N_PHASES];
        int          n_new;
        int          pos;
        int          sent;
        int          pick;
        int          len;
        int          seq;
        logic [7:0]  hdr;

        // Column order: kind, length, header, sequence, sample fill, temp
        // integer byte, temp fraction byte, repeats, dropped, packet_lost,
        // temp_sixteenths, first sample_index, keep, pole.
        script = '{
            // First report after reset: it seeds the sequence number, starts
            // the index at zero and carries the highest temperature.
            '{ROW_REPORT, 20, HDR_OK, 'h10, FILL_RAW_MAX, 8'h7F, 8'h00, 1, 1'b0,
              0, 2032, 0, 16'd0, 16'd0},
            // Sequence gap, lowest temperature.
            '{ROW_REPORT, 20, HDR_OK, 'h12, FILL_MIXED, 8'h80, 8'h0F, 1, 1'b0,
              1, -2063, 4, 16'd0, 16'd0},
            '{ROW_REPORT, 20, HDR_OK, 'h13, FILL_MIXED, 8'h00, 8'h0F, 1, 1'b0,
              0, -15, NOCHK, 16'd0, 16'd0},
            // Short, single-byte, long, very long and wrong-header reports.
            '{ROW_REPORT, 19, HDR_OK, 'h14, FILL_MIXED, 8'h10, 8'h00, 1, 1'b1,
              NOCHK, NOCHK, NOCHK, 16'd0, 16'd0},
            '{ROW_REPORT, 1, HDR_OK, 'h14, FILL_MIXED, 8'h10, 8'h00, 1, 1'b1,
              NOCHK, NOCHK, NOCHK, 16'd0, 16'd0},
            '{ROW_REPORT, 21, HDR_OK, 'h14, FILL_MIXED, 8'h10, 8'h00, 1, 1'b1,
              NOCHK, NOCHK, NOCHK, 16'd0, 16'd0},
            '{ROW_REPORT, 33, HDR_OK, 'h14, FILL_MIXED, 8'h10, 8'h00, 1, 1'b1,
              NOCHK, NOCHK, NOCHK, 16'd0, 16'd0},
            '{ROW_REPORT, 20, 8'h0F, 'h14, FILL_MIXED, 8'h10, 8'h00, 1, 1'b1,
              NOCHK, NOCHK, NOCHK, 16'd0, 16'd0},
            // Dropped reports leave the expected sequence number alone.
            '{ROW_REPORT, 20, HDR_OK, SEQ_NEXT, FILL_MIXED, 8'h01, 8'h08, 1, 1'b0,
              0, 8, NOCHK, 16'd0, 16'd0},
            // Gap up to 0xFF, then the number wraps to zero.
            '{ROW_REPORT, 20, HDR_OK, 'hFF, FILL_MIXED, 8'hFF, 8'h00, 1, 1'b0,
              1, -16, NOCHK, 16'd0, 16'd0},
            '{ROW_REPORT, 20, HDR_OK, 'h00, FILL_MIXED, 8'h7F, 8'h0F, 1, 1'b0,
              0, 2017, NOCHK, 16'd0, 16'd0},
            // With the pole at its top and the lowpass open, full-scale
            // samples pile up quickly in the blocker integrator.
            '{ROW_SETUP, 0, 8'h00, 0, FILL_MIXED, 8'h00, 8'h00, 0, 1'b0,
              NOCHK, NOCHK, NOCHK, 16'd0, 16'd65535},
            '{ROW_REPORT, 20, HDR_OK, SEQ_NEXT, FILL_RAW_MIN, 8'h19, 8'h04, 3, 1'b0,
              0, NOCHK, NOCHK, 16'd0, 16'd0},
            // Dropping the pole to zero then swings AC far below its range.
            '{ROW_SETUP, 0, 8'h00, 0, FILL_MIXED, 8'h00, 8'h00, 0, 1'b0,
              NOCHK, NOCHK, NOCHK, 16'd65535, 16'd0},
            '{ROW_REPORT, 20, HDR_OK, SEQ_NEXT, FILL_RAW_MAX, 8'h19, 8'h04, 1, 1'b0,
              0, NOCHK, NOCHK, 16'd0, 16'd0},
            '{ROW_SETUP, 0, 8'h00, 0, FILL_MIXED, 8'h00, 8'h00, 0, 1'b0,
              NOCHK, NOCHK, NOCHK, ppgf_pkg::KEEP_RESET, ppgf_pkg::POLE_RESET}
        };

        phase_keep = '{16'($urandom), 16'd0, 16'($urandom), 16'd65535};
        phase_pole = '{16'($urandom), 16'd0, 16'($urandom), 16'd65535};
        phase_idle = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

        set_idling(IDLE_NONE);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from the settings the block has after reset; setup rows change them.
        foreach (script[r]) begin
            if (script[r].kind == ROW_SETUP) begin
                settle();
                write_filter_cfg(script[r].keep, script[r].pole);
            end else begin
                for (int rep = 0; rep < script[r].rep; rep++) begin
                    n_new = samples_predicted;
                    send_report(script[r].len, script[r].hdr, script[r].seq, script[r].fill,
                                script[r].t_int, script[r].t_frac);
                    n_new = samples_predicted - n_new;
                    // A dropped report must leave no samples behind.
                    if (script[r].dropped) begin
                        check_field("dropped report samples", 0, n_new);
                    end
                    // Typed values replace the predicted fields; the new
                    // samples are the newest in the buffer at this point.
                    for (int j = 0; j < n_new; j++) begin
                        pos = (pend_wr - n_new + j) % Q_DEPTH;
                        if (script[r].exp_lost != NOCHK) begin
                            pend_q[pos].lost = script[r].exp_lost[0];
                        end
                        if (script[r].exp_temp != NOCHK) begin
                            pend_q[pos].temp = script[r].exp_temp[12:0];
                        end
                        if (script[r].exp_idx != NOCHK) begin
                            pend_q[pos].index = 32'(script[r].exp_idx + j);
                        end
                    end
                end
            end
        end

        // Random part: mostly well-formed reports in sequence, with some
        // sequence gaps, short, long and wrong-header reports mixed in.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            write_filter_cfg(phase_keep[ph], phase_pole[ph]);
            set_idling(phase_idle[ph]);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                len  = RPT_LEN;
                hdr  = ppgf_pkg::REPORT_HEADER;
                seq  = $urandom_range(0, 255);
                if (pick < 80) begin
                    if ($urandom_range(0, 9) != 0) begin
                        seq = SEQ_NEXT;
                    end
                end else if (pick < 88) begin
                    len = $urandom_range(1, RPT_LEN - 1);
                    if ($urandom_range(0, 1) != 0) begin
                        hdr = 8'($urandom);
                    end
                end else if (pick < 94) begin
                    hdr = 8'($urandom);
                    if (hdr == ppgf_pkg::REPORT_HEADER) begin
                        hdr = ~hdr;
                    end
                end else begin
                    len = $urandom_range(RPT_LEN + 1, 36);
                end
                send_report(len, hdr, seq, FILL_MIXED, 8'($urandom), 8'($urandom));
                sent += len;
            end
        end

        settle();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
